// ----- rtl/core/first_fit_staging_allocator_defines.svh -----
// Assertion macros used by the allocator port checker.
`ifndef FIRST_FIT_STAGING_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_STAGING_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, skipped while reset is high.
`define FFSA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed: same-cycle implication");

// Next-cycle implication, skipped while reset is high.
`define FFSA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed: next-cycle implication");

`endif

// ----- rtl/core/ffsa_pkg.sv -----
// Shared types and constants of the first-fit staging allocator.
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam logic [1:0] OP_ALLOC    = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_FLUSH    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [31:0] BUF_SIZE_RESET = 32'd67108864;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] start_off;
    logic [31:0] len;
    logic [7:0]  tag;
  } entry_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic flush_all;
    logic set_too_large;
    logic scan_step;
    logic begin_insert;
    logic begin_remove;
    logic shift_step;
    logic insert;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       oversize;
    logic       scan_done;
    logic       found;
    logic       need_flush;
    logic       shift_needed;
    logic       shift_done;
  } sts_t;

endpackage

// ----- rtl/core/first_fit_staging_allocator.sv -----
// Top level of the first-fit staging allocator.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-----------------------
//  request  | operation, request_size, release_tag         | start high, busy low
//  result   | region_offset, region_tag, flushed, too_large| done, one cycle, no stall
//  config   | cfg_data (buffer_size)                       | cfg_write, no wait
//
// One request at a time. An allocation or a release walks the region table, so
// its time depends on the number of live regions; a flush, an oversized request
// or an unused operation code goes from dispatch straight to done. The single
// read port of the region table sets the walk: the scan reads one entry a cycle
// up to the chosen slot and the insert or remove shift moves one entry a cycle
// from there on. Synchronous reset empties the table and resets buffer_size to
// 64 MiB; no clearing pass is needed. done pulses for one cycle and cannot be
// stalled; the next request is taken in the cycle after it.
`timescale 1ns / 1ps
module first_fit_staging_allocator #(
  parameter int MAX_REGIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] request_size,
  input  logic [7:0]  release_tag,
  output logic        done,
  output logic [31:0] region_offset,
  output logic [7:0]  region_tag,
  output logic        flushed,
  output logic        too_large
);

  ffsa_pkg::cmd_t cmd;
  ffsa_pkg::sts_t sts;

  // Sequence the request: dispatch, scan, decide, shift, write, report.
  ffsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Hold the sorted region table, the scan cursor and the result registers.
  ffsa_datapath #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .request_size  (request_size),
    .release_tag   (release_tag),
    .cmd           (cmd),
    .sts           (sts),
    .region_offset (region_offset),
    .region_tag    (region_tag),
    .flushed       (flushed),
    .too_large     (too_large)
  );

endmodule

// ----- rtl/core/ffsa_ctrl.sv -----
// Controller state machine of the allocator.
`timescale 1ns / 1ps
module ffsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ffsa_pkg::sts_t  sts,
  output ffsa_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  ffsa_pkg::state_t state;
  ffsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ffsa_pkg::ST_IDLE: begin
        if (start) state_next = ffsa_pkg::ST_DISPATCH;
      end
      ffsa_pkg::ST_DISPATCH: begin
        case (sts.op)
          ffsa_pkg::OP_ALLOC: begin
            state_next = sts.oversize ? ffsa_pkg::ST_DONE : ffsa_pkg::ST_SCAN;
          end
          ffsa_pkg::OP_RELEASE: state_next = ffsa_pkg::ST_SCAN;
          default:              state_next = ffsa_pkg::ST_DONE;
        endcase
      end
      ffsa_pkg::ST_SCAN: begin
        if (sts.scan_done) state_next = ffsa_pkg::ST_DECIDE;
      end
      ffsa_pkg::ST_DECIDE: begin
        if (sts.op == ffsa_pkg::OP_ALLOC) begin
          if (sts.need_flush) state_next = ffsa_pkg::ST_WRITE;
          else if (sts.shift_needed) state_next = ffsa_pkg::ST_SHIFT;
          else state_next = ffsa_pkg::ST_WRITE;
        end else begin
          state_next = sts.found ? ffsa_pkg::ST_SHIFT : ffsa_pkg::ST_DONE;
        end
      end
      ffsa_pkg::ST_SHIFT: begin
        if (sts.shift_done) begin
          state_next = (sts.op == ffsa_pkg::OP_ALLOC) ? ffsa_pkg::ST_WRITE
                                                       : ffsa_pkg::ST_DONE;
        end
      end
      ffsa_pkg::ST_WRITE: state_next = ffsa_pkg::ST_DONE;
      ffsa_pkg::ST_DONE:  state_next = ffsa_pkg::ST_IDLE;
      default:            state_next = ffsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ffsa_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ffsa_pkg::ST_DISPATCH: begin
        cmd.prep = 1'b1;
        case (sts.op)
          ffsa_pkg::OP_ALLOC: cmd.set_too_large = sts.oversize;
          ffsa_pkg::OP_FLUSH: cmd.flush_all = 1'b1;
          default:            cmd.flush_all = 1'b0;
        endcase
      end
      ffsa_pkg::ST_SCAN: cmd.scan_step = !sts.scan_done;
      ffsa_pkg::ST_DECIDE: begin
        if (sts.op == ffsa_pkg::OP_ALLOC) begin
          if (sts.need_flush) cmd.flush_all = 1'b1;
          else cmd.begin_insert = sts.shift_needed;
        end else begin
          cmd.begin_remove = sts.found;
        end
      end
      ffsa_pkg::ST_SHIFT: cmd.shift_step = !sts.shift_done;
      ffsa_pkg::ST_WRITE: cmd.insert = 1'b1;
      ffsa_pkg::ST_DONE:  done = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

endmodule

// ----- rtl/core/ffsa_datapath.sv -----
// Region table, scan cursor and result registers of the allocator.
`timescale 1ns / 1ps
module ffsa_datapath #(
  parameter int MAX_REGIONS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [31:0]     cfg_data,
  input  logic [1:0]      operation,
  input  logic [31:0]     request_size,
  input  logic [7:0]      release_tag,
  input  ffsa_pkg::cmd_t  cmd,
  output ffsa_pkg::sts_t  sts,
  output logic [31:0]     region_offset,
  output logic [7:0]      region_tag,
  output logic            flushed,
  output logic            too_large
);

  localparam int AW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  ffsa_pkg::entry_t mem [MAX_REGIONS];
  ffsa_pkg::entry_t rd_data;
  ffsa_pkg::entry_t wdata;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;

  logic [31:0]   buffer_size;
  logic [CW-1:0] count;
  logic [7:0]    next_id;
  logic [CW-1:0] ridx;
  logic [CW-1:0] left;
  logic          pvalid;
  logic          found;

  logic [1:0]    op_r;
  logic [31:0]   size_r;
  logic [7:0]    tag_r;
  logic [32:0]   cur;
  logic [CW-1:0] pos;
  logic [AW-1:0] pidx;

  logic [33:0]   cur_plus_size;
  logic          fit;
  logic          up;
  logic          scan_issue;
  logic          shift_issue;

  assign up            = (op_r == ffsa_pkg::OP_ALLOC);
  assign cur_plus_size = {1'b0, cur} + {2'b00, size_r};
  assign fit = up ? ({2'b00, rd_data.start_off} >= cur_plus_size)
                  : (rd_data.tag == tag_r);
  assign scan_issue  = (ridx != count);
  assign shift_issue = (left != '0);

  always_comb begin
    sts              = '0;
    sts.op           = op_r;
    sts.oversize     = (size_r > buffer_size);
    sts.found        = found;
    sts.scan_done    = found || (!pvalid && !scan_issue);
    sts.need_flush   = (count == CW'(MAX_REGIONS)) ||
                       (cur_plus_size > {2'b00, buffer_size});
    sts.shift_needed = (pos != count);
    sts.shift_done   = !pvalid && !shift_issue;
  end

  // Table port: one write, one registered read.
  always_comb begin
    raddr = ridx[AW-1:0];
    we    = 1'b0;
    waddr = pos[AW-1:0];
    wdata = '{start_off: cur[31:0], len: size_r, tag: next_id};
    if (cmd.shift_step && pvalid) begin
      we    = 1'b1;
      waddr = up ? (pidx + AW'(1)) : (pidx - AW'(1));
      wdata = rd_data;
    end
    if (cmd.insert) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= ffsa_pkg::BUF_SIZE_RESET;
      count       <= '0;
      next_id     <= '0;
      ridx        <= '0;
      left        <= '0;
      pvalid      <= 1'b0;
      found       <= 1'b0;
    end else begin
      if (cfg_write) buffer_size <= cfg_data;
      if (cmd.prep) begin
        ridx   <= '0;
        pvalid <= 1'b0;
        found  <= 1'b0;
      end
      if (cmd.flush_all) count <= '0;
      if (cmd.scan_step) begin
        if (scan_issue) ridx <= ridx + CW'(1);
        pvalid <= scan_issue;
        if (pvalid && !found && fit) found <= 1'b1;
      end
      if (cmd.begin_insert) begin
        ridx   <= count - CW'(1);
        left   <= count - pos;
        pvalid <= 1'b0;
      end
      if (cmd.begin_remove) begin
        ridx   <= pos + CW'(1);
        left   <= count - CW'(1) - pos;
        count  <= count - CW'(1);
        pvalid <= 1'b0;
      end
      if (cmd.shift_step) begin
        if (shift_issue) begin
          ridx <= up ? (ridx - CW'(1)) : (ridx + CW'(1));
          left <= left - CW'(1);
        end
        pvalid <= shift_issue;
      end
      if (cmd.insert) begin
        count   <= count + CW'(1);
        next_id <= next_id + 8'd1;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= operation;
      size_r <= request_size;
      tag_r  <= release_tag;
    end
    if (cmd.prep) begin
      cur           <= '0;
      pos           <= count;
      region_offset <= '0;
      region_tag    <= '0;
      flushed       <= 1'b0;
      too_large     <= 1'b0;
    end
    if (cmd.set_too_large) too_large <= 1'b1;
    if (cmd.flush_all) begin
      flushed <= 1'b1;
      pos     <= '0;
      cur     <= '0;
    end
    if (cmd.scan_step) begin
      if (scan_issue) pidx <= ridx[AW-1:0];
      if (pvalid && !found) begin
        if (fit) pos <= CW'(pidx);
        else if (up) cur <= {1'b0, rd_data.start_off} + {1'b0, rd_data.len};
      end
    end
    if (cmd.shift_step && shift_issue) pidx <= ridx[AW-1:0];
    if (cmd.insert) begin
      region_offset <= cur[31:0];
      region_tag    <= next_id;
    end
  end

endmodule

// ----- rtl/core/ffsa_checker.sv -----
// Port-level checks of the allocator and their bind.
`timescale 1ns / 1ps
`include "first_fit_staging_allocator_defines.svh"
module ffsa_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] region_offset,
  input logic [7:0]  region_tag,
  input logic        flushed,
  input logic        too_large
);

  logic zero_grant;

  assign zero_grant = (region_offset == 32'd0) && (region_tag == 8'd0) && !flushed;

  `FFSA_ASSERT_IMP(a_done_while_busy, clk, rst, done, busy)
  `FFSA_ASSERT_NXT(a_accept_sets_busy, clk, rst, start && !busy, busy && !done)
  `FFSA_ASSERT_NXT(a_done_one_cycle, clk, rst, done, !done && !busy)
  `FFSA_ASSERT_IMP(a_too_large_clean, clk, rst, done && too_large, zero_grant)
  `FFSA_ASSERT_IMP(a_idle_after_done, clk, rst, !$past(rst) && $fell(busy), $past(done))

endmodule

bind first_fit_staging_allocator ffsa_port_checker u_ffsa_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .region_offset (region_offset),
  .region_tag    (region_tag),
  .flushed       (flushed),
  .too_large     (too_large)
);
